@@ rtl/sptp_pkg.sv @@
// Package with the types, codes and tables shared by the picture-timing SEI parser.
`default_nettype none

package sptp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned ShiftW   = 32;
  localparam int unsigned ValueW   = 33;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DELAYS_PRESENT = 3'd0,
    CFG_CPB_DELAY_BITS = 3'd1,
    CFG_DPB_DELAY_BITS = 3'd2,
    CFG_OFFSET_BITS    = 3'd3,
    CFG_STRUCT_PRESENT = 3'd4
  } cfg_reg_e;

  typedef enum logic [4:0] {
    FC_CPB_DELAY  = 5'd0,
    FC_DPB_DELAY  = 5'd1,
    FC_PIC_STRUCT = 5'd2,
    FC_TS_FLAG    = 5'd3,
    FC_CT_TYPE    = 5'd4,
    FC_NUIT       = 5'd5,
    FC_COUNTING   = 5'd6,
    FC_FULL       = 5'd7,
    FC_DISCONT    = 5'd8,
    FC_DROPPED    = 5'd9,
    FC_N_FRAMES   = 5'd10,
    FC_SEC        = 5'd11,
    FC_MIN        = 5'd12,
    FC_HOUR       = 5'd13,
    FC_SEC_FLAG   = 5'd14,
    FC_MIN_FLAG   = 5'd15,
    FC_HOUR_FLAG  = 5'd16,
    FC_OFFSET     = 5'd17,
    FC_NONE       = 5'd31
  } field_e;

  localparam logic [3:0] MaxPicStruct = 4'd8;
  localparam logic [4:0] MaxCounting  = 5'd6;
  localparam logic [5:0] MaxSecMin    = 6'd59;
  localparam logic [4:0] MaxHour      = 5'd23;

  typedef struct packed {
    logic       delays_present;
    logic [5:0] cpb_delay_bits;
    logic [5:0] dpb_delay_bits;
    logic [4:0] offset_bits;
    logic       struct_present;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    field_e                   code;
    logic signed [ValueW-1:0] value;
    logic [1:0]               stamp;
    logic                     range_error;
    logic                     message_done;
  } res_t;

  // Number of clock timestamps that follow each legal picture structure value.
  function automatic logic [1:0] clock_ts_count(input logic [3:0] struct_code);
    logic [1:0] cnt;
    unique case (struct_code)
      4'd0, 4'd1, 4'd2: cnt = 2'd1;
      4'd3, 4'd4, 4'd7: cnt = 2'd2;
      4'd5, 4'd6, 4'd8: cnt = 2'd3;
      default:          cnt = 2'd0;
    endcase
    return cnt;
  endfunction

  function automatic logic [5:0] clamp_len(input logic [5:0] n);
    logic [5:0] len;
    if (n == 6'd0) begin
      len = 6'd1;
    end else if (n > 6'd32) begin
      len = 6'd32;
    end else begin
      len = n;
    end
    return len;
  endfunction

  function automatic logic [5:0] field_len(input field_e code, input cfg_t cfg);
    logic [5:0] len;
    unique case (code)
      FC_CPB_DELAY:     len = clamp_len(cfg.cpb_delay_bits);
      FC_DPB_DELAY:     len = clamp_len(cfg.dpb_delay_bits);
      FC_PIC_STRUCT:    len = 6'd4;
      FC_CT_TYPE:       len = 6'd2;
      FC_COUNTING:      len = 6'd5;
      FC_N_FRAMES:      len = 6'd8;
      FC_SEC, FC_MIN:   len = 6'd6;
      FC_HOUR:          len = 6'd5;
      FC_OFFSET:        len = {1'b0, cfg.offset_bits};
      default:          len = 6'd1;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sptp_if.sv @@
// Handshake interfaces for the bit input, field result and register write channels.
`default_nettype none

interface sptp_bit_if;
  logic valid;
  logic ready;
  logic payload_bit;
  logic start_req;

  modport source (output valid, output payload_bit, output start_req, input ready);
  modport sink   (input valid, input payload_bit, input start_req, output ready);
endinterface

interface sptp_field_if;
  logic               valid;
  logic               ready;
  logic [4:0]         field_code;
  logic signed [32:0] field_value;
  logic [1:0]         stamp_index;
  logic               range_error;
  logic               message_done;

  modport source (output valid, output field_code, output field_value, output stamp_index,
                  output range_error, output message_done, input ready);
  modport sink   (input valid, input field_code, input field_value, input stamp_index,
                  input range_error, input message_done, output ready);
endinterface

interface sptp_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [5:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sptp_cfg_regs.sv @@
// Configuration register file of the parser, written through the register write channel.
`default_nettype none

module sptp_cfg_regs
  import sptp_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sptp_cfg_if.sink    cfg_ch,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delays_present <= 1'b0;
      cfg_q.cpb_delay_bits <= 6'd24;
      cfg_q.dpb_delay_bits <= 6'd24;
      cfg_q.offset_bits    <= 5'd24;
      cfg_q.struct_present <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_DELAYS_PRESENT: cfg_q.delays_present <= cfg_ch.data[0];
        CFG_CPB_DELAY_BITS: cfg_q.cpb_delay_bits <= cfg_ch.data;
        CFG_DPB_DELAY_BITS: cfg_q.dpb_delay_bits <= cfg_ch.data;
        CFG_OFFSET_BITS:    cfg_q.offset_bits    <= cfg_ch.data[4:0];
        CFG_STRUCT_PRESENT: cfg_q.struct_present <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/sptp_parser.sv @@
// Field sequencer and value shifter that turn one payload bit per step into field results.
`default_nettype none

module sptp_parser
  import sptp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic bit_i,
  input  wire logic start_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  field_e              phase_q, phase_d;
  logic [5:0]          bits_q, bits_d;
  logic [ShiftW-1:0]   shift_q, shift_d;
  logic [1:0]          sn_q, sn_d;
  logic [1:0]          st_q, st_d;
  logic                fs_q, fs_d;

  logic                skip;
  logic [ShiftW-1:0]   v;
  logic [4:0]          sign_pos;
  logic                err;
  field_e              nxt;
  logic [ValueW-1:0]   val;

  always_comb begin
    phase_d  = phase_q;
    bits_d   = bits_q;
    shift_d  = shift_q;
    sn_d     = sn_q;
    st_d     = st_q;
    fs_d     = fs_q;
    skip     = 1'b0;
    err      = 1'b0;
    nxt      = FC_NONE;
    v        = '0;
    val      = '0;
    sign_pos = cfg_i.offset_bits - 5'd1;
    res_o    = '0;

    if (start_i) begin
      sn_d    = '0;
      st_d    = '0;
      fs_d    = 1'b0;
      shift_d = '0;
      if (cfg_i.delays_present) begin
        phase_d = FC_CPB_DELAY;
        bits_d  = field_len(FC_CPB_DELAY, cfg_i);
      end else if (cfg_i.struct_present) begin
        phase_d = FC_PIC_STRUCT;
        bits_d  = field_len(FC_PIC_STRUCT, cfg_i);
      end else begin
        phase_d = FC_NONE;
        bits_d  = '0;
        skip    = 1'b1;
      end
    end

    if (!skip && phase_d <= FC_OFFSET && bits_d != 6'd0) begin
      shift_d = {shift_d[ShiftW-2:0], bit_i};
      bits_d  = bits_d - 6'd1;
      if (bits_d == 6'd0) begin
        v   = shift_d;
        val = {1'b0, v};
        if (phase_d == FC_OFFSET && cfg_i.offset_bits != 5'd0 && v[sign_pos]) begin
          val = val | ({ValueW{1'b1}} << cfg_i.offset_bits);
        end
        res_o.valid = 1'b1;
        res_o.code  = phase_d;
        res_o.value = $signed(val);
        res_o.stamp = (phase_d >= FC_TS_FLAG) ? sn_d : 2'd0;

        // Pick the next field; the timestamp count moves on where a stamp ends.
        unique case (phase_d)
          FC_CPB_DELAY: nxt = FC_DPB_DELAY;
          FC_DPB_DELAY: nxt = cfg_i.struct_present ? FC_PIC_STRUCT : FC_NONE;
          FC_PIC_STRUCT: begin
            if (v > ShiftW'(MaxPicStruct)) begin
              err = 1'b1;
            end else begin
              st_d = clock_ts_count(v[3:0]);
              sn_d = '0;
              nxt  = FC_TS_FLAG;
            end
          end
          FC_TS_FLAG: begin
            if (v != '0) begin
              nxt = FC_CT_TYPE;
            end else begin
              sn_d = sn_d + 2'd1;
              nxt  = (sn_d < st_d) ? FC_TS_FLAG : FC_NONE;
            end
          end
          FC_CT_TYPE: nxt = FC_NUIT;
          FC_NUIT:    nxt = FC_COUNTING;
          FC_COUNTING: begin
            if (v > ShiftW'(MaxCounting)) begin
              err = 1'b1;
            end else begin
              nxt = FC_FULL;
            end
          end
          FC_FULL: begin
            fs_d = v[0];
            nxt  = FC_DISCONT;
          end
          FC_DISCONT:  nxt = FC_DROPPED;
          FC_DROPPED:  nxt = FC_N_FRAMES;
          FC_N_FRAMES: nxt = fs_d ? FC_SEC : FC_SEC_FLAG;
          FC_SEC: begin
            if (v > ShiftW'(MaxSecMin)) begin
              err = 1'b1;
            end else begin
              nxt = fs_d ? FC_MIN : FC_MIN_FLAG;
            end
          end
          FC_MIN: begin
            if (v > ShiftW'(MaxSecMin)) begin
              err = 1'b1;
            end else begin
              nxt = fs_d ? FC_HOUR : FC_HOUR_FLAG;
            end
          end
          FC_HOUR, FC_SEC_FLAG, FC_MIN_FLAG, FC_HOUR_FLAG, FC_OFFSET: begin
            if (phase_d == FC_HOUR && v > ShiftW'(MaxHour)) begin
              err = 1'b1;
            end else if (phase_d == FC_SEC_FLAG && v != '0) begin
              nxt = FC_SEC;
            end else if (phase_d == FC_MIN_FLAG && v != '0) begin
              nxt = FC_MIN;
            end else if (phase_d == FC_HOUR_FLAG && v != '0) begin
              nxt = FC_HOUR;
            end else if (phase_d != FC_OFFSET && cfg_i.offset_bits != 5'd0) begin
              nxt = FC_OFFSET;
            end else begin
              sn_d = sn_d + 2'd1;
              nxt  = (sn_d < st_d) ? FC_TS_FLAG : FC_NONE;
            end
          end
          default: nxt = FC_NONE;
        endcase

        res_o.range_error  = err;
        res_o.message_done = !err && (nxt == FC_NONE);
        if (err || nxt == FC_NONE) begin
          phase_d = FC_NONE;
          bits_d  = '0;
          shift_d = '0;
        end else begin
          phase_d = nxt;
          bits_d  = field_len(nxt, cfg_i);
          shift_d = '0;
        end
      end
    end

    res_o.valid = res_o.valid & step_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= FC_NONE;
      bits_q  <= '0;
      shift_q <= '0;
      sn_q    <= '0;
      st_q    <= '0;
      fs_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      sn_q    <= sn_d;
      st_q    <= st_d;
      fs_q    <= fs_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sei_pic_timing_parser_unit.sv @@
// Top level of the picture-timing SEI parser: input register, parser and result register.
// A field result is registered when the parser takes its last bit from the input register.
// Throughput: one payload bit per cycle unless a held result register stalls the input.
// A full result register that is not taken stalls the input register and then the input.
// Reset clears the parser to idle, empties both registers and loads register defaults.
`default_nettype none

module sei_pic_timing_parser_unit
  import sptp_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sptp_bit_if.sink     in_ch,
  sptp_field_if.source out_ch,
  sptp_cfg_if.sink     cfg_ch
);

  cfg_t cfg;
  res_t res;

  logic in_v_q;
  logic in_bit_q;
  logic in_start_q;
  logic advance;
  logic in_ready;

  logic               out_v_q;
  logic [4:0]         code_q;
  logic signed [32:0] value_q;
  logic [1:0]         stamp_q;
  logic               err_q;
  logic               done_q;

  assign advance     = in_v_q && (!out_v_q || out_ch.ready);
  assign in_ready    = !in_v_q || advance;
  assign in_ch.ready = in_ready;

  sptp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  sptp_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .bit_i   (in_bit_q),
    .start_i (in_start_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_ch.valid && in_ready) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (res.valid) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ready) begin
      in_bit_q   <= in_ch.payload_bit;
      in_start_q <= in_ch.start_req;
    end
    if (res.valid) begin
      code_q  <= res.code;
      value_q <= res.value;
      stamp_q <= res.stamp;
      err_q   <= res.range_error;
      done_q  <= res.message_done;
    end
  end

  assign out_ch.valid        = out_v_q;
  assign out_ch.field_code   = code_q;
  assign out_ch.field_value  = value_q;
  assign out_ch.stamp_index  = stamp_q;
  assign out_ch.range_error  = err_q;
  assign out_ch.message_done = done_q;

`ifndef SYNTH
  a_no_err_and_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(err_q && done_q))
    else $error("result flags both an error and the end of the payload");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && err_q) |-> (code_q == FC_PIC_STRUCT || code_q == FC_COUNTING ||
                            code_q == FC_SEC || code_q == FC_MIN || code_q == FC_HOUR))
    else $error("range error on a field that has no range check");

  a_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && code_q < FC_TS_FLAG) |-> (stamp_q == 2'd0))
    else $error("stamp index set on a field outside the timestamps");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ch.ready) |-> !res.valid)
    else $error("new result while the result register is held");
`endif

endmodule

`default_nettype wire
